@@ rtl/core/bia_pkg.sv @@
// Shared constants and status codes for the bitmap identifier allocator.
package bia_pkg;

    // Pool size and the bitmap geometry derived from it.
    localparam int NUM_IDS    = 4096;
    localparam int WORD_W     = 32;
    localparam int WORD_COUNT = (NUM_IDS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int IDX_W      = WORD_AW + 5;

    // Field widths.
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;

    // Pool size as a 17-bit value, so that it compares against any 16-bit offset.
    localparam logic [ID_W:0] NUM_IDS_L = (ID_W + 1)'(NUM_IDS);

    // Identifier that index zero maps to after reset.
    localparam logic [ID_W-1:0] BASE_RESET = ID_W'(300);

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_GRANTED      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

endpackage

@@ rtl/core/bia_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bitmap_id_allocator.sv @@
// Bitmap identifier allocator: top level with its control sequencer and bitmap memory.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-------------------------
//  request  | in        | i_in_valid / o_in_stall    | i_mode, i_id
//  result   | out       | o_out_valid / i_out_stall  | o_status, o_granted_id
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (base_id)
//
// An allocate request scans the bitmap memory one word per cycle from word zero;
// the single read port of the bitmap memory sets that pace. A release reads its
// word and writes it back with the bit cleared; a release out of range goes
// straight to the result. Reset is synchronous; a valid bit per word makes the
// whole bitmap read as free at once, with no clearing pass. A finished result
// waits in the output register, and the next request is accepted meanwhile.
module bitmap_id_allocator
    import bia_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_mode,
    input  logic [ID_W-1:0]     i_id,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_granted_id,
    // Configuration channel.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ID_W-1:0]     i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_REL_RD = 3'd2;
    localparam logic [2:0] S_REL_WR = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);

    logic [2:0]          r_state, n_state;
    logic [ID_W-1:0]     r_base;
    logic [WORD_AW-1:0]  r_scan_addr, n_scan_addr;
    logic                r_issue, n_issue;
    logic                r_chk, n_chk;
    logic [WORD_AW-1:0]  r_chk_addr;
    logic                r_chk_vld;
    logic [WORD_AW-1:0]  r_word_addr, n_word_addr;
    logic [4:0]          r_bit, n_bit;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [ID_W-1:0]     r_res_id, n_res_id;
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic [ID_W-1:0]     r_out_id;
    logic [WORD_COUNT-1:0] r_word_vld;

    logic                in_accept;
    logic                out_free;
    logic [ID_W-1:0]     rel_off;
    logic                rel_in_range;
    logic                ram_we;
    logic [WORD_AW-1:0]  ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [WORD_AW-1:0]  ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   cur_word;
    logic [WORD_W-1:0]   free_bits;
    logic [4:0]          free_bit;
    logic [IDX_W-1:0]    found_idx;
    logic                found_ok;

    // Bitmap memory, one 32-bit word per group of ids.
    bia_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshakes.
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || !i_out_stall;

    // Release offset relative to the current base.
    assign rel_off      = i_id - r_base;
    assign rel_in_range = ({1'b0, rel_off} < NUM_IDS_L);

    // A word that was never written reads as all free.
    assign cur_word  = r_chk_vld ? ram_rdata : '0;
    assign free_bits = ~cur_word;

    // Lowest free bit of the word under test.
    always_comb begin
        free_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                free_bit = 5'(b);
            end
        end
    end

    assign found_idx = {r_chk_addr, free_bit};
    assign found_ok  = ({{(ID_W + 1 - IDX_W){1'b0}}, found_idx} < NUM_IDS_L);

    // Memory read address: the scan pointer, or the word of a release.
    assign ram_raddr = (r_state == S_REL_RD) ? r_word_addr : r_scan_addr;
    assign ram_re    = ((r_state == S_SCAN) && r_issue) || (r_state == S_REL_RD);

    // Sequencer next-state logic and memory write-back.
    always_comb begin
        n_state      = r_state;
        n_scan_addr  = r_scan_addr;
        n_issue      = r_issue;
        n_chk        = 1'b0;
        n_word_addr  = r_word_addr;
        n_bit        = r_bit;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        ram_we       = 1'b0;
        ram_waddr    = r_chk_addr;
        ram_wdata    = cur_word;

        unique case (r_state)
            S_IDLE: begin
                n_issue = 1'b0;
                if (in_accept) begin
                    if (!i_mode) begin
                        n_state     = S_SCAN;
                        n_scan_addr = '0;
                        n_issue     = 1'b1;
                    end else if (rel_in_range) begin
                        n_state     = S_REL_RD;
                        n_word_addr = rel_off[5 +: WORD_AW];
                        n_bit       = rel_off[4:0];
                    end else begin
                        n_state      = S_DONE;
                        n_res_status = ST_OUT_OF_RANGE;
                        n_res_id     = '0;
                    end
                end
            end
            S_SCAN: begin
                // Keep issuing reads while the last word is not yet requested.
                n_chk = r_issue;
                if (r_issue) begin
                    if (r_scan_addr == LAST_WORD) begin
                        n_issue = 1'b0;
                    end else begin
                        n_scan_addr = r_scan_addr + 1'b1;
                    end
                end
                // Test the word that has come back.
                if (r_chk) begin
                    if (free_bits != '0) begin
                        n_state = S_DONE;
                        n_issue = 1'b0;
                        n_chk   = 1'b0;
                        if (found_ok) begin
                            ram_we          = 1'b1;
                            ram_wdata       = cur_word | (WORD_W'(1) << free_bit);
                            n_res_status    = ST_GRANTED;
                            n_res_id        = r_base + ID_W'(found_idx);
                        end else begin
                            n_res_status = ST_NONE_FREE;
                            n_res_id     = '0;
                        end
                    end else if (r_chk_addr == LAST_WORD) begin
                        n_state      = S_DONE;
                        n_issue      = 1'b0;
                        n_chk        = 1'b0;
                        n_res_status = ST_NONE_FREE;
                        n_res_id     = '0;
                    end
                end
            end
            S_REL_RD: begin
                n_state = S_REL_WR;
            end
            S_REL_WR: begin
                ram_we       = 1'b1;
                ram_waddr    = r_word_addr;
                ram_wdata    = cur_word & ~(WORD_W'(1) << r_bit);
                n_res_status = ST_RELEASED;
                n_res_id     = '0;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= 1'b0;
            r_chk      <= 1'b0;
            r_out_vld  <= 1'b0;
            r_base     <= BASE_RESET;
            r_word_vld <= '0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_chk   <= n_chk;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
            if (ram_we) begin
                r_word_vld[ram_waddr] <= 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_scan_addr  <= n_scan_addr;
        r_word_addr  <= n_word_addr;
        r_bit        <= n_bit;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_chk_addr   <= ram_raddr;
        r_chk_vld    <= r_word_vld[ram_raddr];
        if ((r_state == S_DONE) && out_free) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_out_status;
    assign o_granted_id = r_out_id;

`ifndef SYNTHESIS
    // The bitmap is written only when a scan finds a word or a release writes back.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_SCAN) || (r_state == S_REL_WR)))
        else $error("bitmap written outside scan or release write-back");

    // Only a grant carries a nonzero identifier.
    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_GRANTED)) |-> (o_granted_id == '0))
        else $error("nonzero identifier on a result that is not a grant");

    // An accepted request always starts work on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted request left the sequencer idle");

    // A word under test during a scan was requested on the previous cycle.
    a_chk_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_chk) |-> $past(r_issue))
        else $error("scan tested a word that was never read");
`endif

endmodule
